// File: design/hsv2rgb_pkg.sv
// Package for the HSV to RGB converter: field widths, fixed-point constants,
// sector codes and the payload structs passed between pipeline stages.
// No dependencies.
package hsv2rgb_pkg;

    localparam int unsigned HUE_W  = 9;
    localparam int unsigned CH_W   = 8;
    localparam int unsigned FRAC_W = 6;
    localparam int unsigned NUM_W  = 14;
    localparam int unsigned PP_W   = 2 * CH_W;
    localparam int unsigned QP_W   = CH_W + NUM_W;

    localparam logic [HUE_W-1:0]  HUE_FULL   = 9'd360;
    localparam logic [HUE_W-1:0]  SECTOR_DEG = 9'd60;
    localparam logic [CH_W-1:0]   CH_MAX     = 8'd255;
    localparam logic [NUM_W-1:0]  FRAC_SCALE = 14'd15300;

    // floor(x / 255) = (x * P_RECIP) >> 24 for x < 2**16
    localparam logic [16:0]       P_RECIP = 17'd65794;
    localparam int unsigned       P_MUL_W = PP_W + 17;
    // floor(x / 15300) = (x * Q_RECIP) >> 36 for x < 2**22
    localparam logic [22:0]       Q_RECIP = 23'd4491470;
    localparam int unsigned       Q_MUL_W = QP_W + 23;

    typedef enum logic [2:0] {
        SEC_RED_YEL  = 3'd0,
        SEC_YEL_GRN  = 3'd1,
        SEC_GRN_CYN  = 3'd2,
        SEC_CYN_BLU  = 3'd3,
        SEC_BLU_MAG  = 3'd4,
        SEC_MAG_RED  = 3'd5
    } sector_t;

    typedef struct packed {
        sector_t           sector;
        logic [FRAC_W-1:0] frac;
        logic [CH_W-1:0]   sat;
        logic [CH_W-1:0]   val;
    } sect_data_t;

    typedef struct packed {
        sector_t          sector;
        logic [CH_W-1:0]  val;
        logic [NUM_W-1:0] q_num;
        logic [NUM_W-1:0] t_num;
        logic [PP_W-1:0]  p_prod;
    } scale_data_t;

    typedef struct packed {
        sector_t         sector;
        logic [CH_W-1:0] val;
        logic [QP_W-1:0] q_prod;
        logic [QP_W-1:0] t_prod;
        logic [CH_W-1:0] p;
    } mult_data_t;

endpackage

// File: design/hsv2rgb_if.sv
// Channel interfaces of the HSV to RGB converter: HSV pixel in, RGB pixel out.
// Depends on hsv2rgb_pkg.
interface hsv2rgb_hsv_if;
    import hsv2rgb_pkg::*;

    logic              valid;
    logic              ready;
    logic [HUE_W-1:0]  hue;
    logic [CH_W-1:0]   saturation;
    logic [CH_W-1:0]   brightness;

    modport source (output valid, hue, saturation, brightness, input ready);
    modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv2rgb_rgb_if;
    import hsv2rgb_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

// File: design/hsv2rgb_sector_stage.sv
// Stage 1: fold hue into 0..359 and split it into sector and fraction.
// Depends on hsv2rgb_pkg and the channel interfaces.
module hsv2rgb_sector_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    hsv2rgb_hsv_if.sink             pix_in,
    output logic                    dn_valid,
    input  logic                    dn_ready,
    output hsv2rgb_pkg::sect_data_t dn_data
);
    import hsv2rgb_pkg::*;

    logic             valid_reg;
    sect_data_t       data_reg;
    sect_data_t       data_next;
    logic [HUE_W-1:0] hue_fold;
    logic [HUE_W-1:0] frac_full;

    assign pix_in.ready = !valid_reg || dn_ready;

    always_comb
    begin
        hue_fold = (pix_in.hue >= HUE_FULL) ? (pix_in.hue - HUE_FULL) : pix_in.hue;
        priority if (hue_fold >= 9'(5 * SECTOR_DEG))
        begin
            data_next.sector = SEC_MAG_RED;
            frac_full        = hue_fold - 9'(5 * SECTOR_DEG);
        end
        else if (hue_fold >= 9'(4 * SECTOR_DEG))
        begin
            data_next.sector = SEC_BLU_MAG;
            frac_full        = hue_fold - 9'(4 * SECTOR_DEG);
        end
        else if (hue_fold >= 9'(3 * SECTOR_DEG))
        begin
            data_next.sector = SEC_CYN_BLU;
            frac_full        = hue_fold - 9'(3 * SECTOR_DEG);
        end
        else if (hue_fold >= 9'(2 * SECTOR_DEG))
        begin
            data_next.sector = SEC_GRN_CYN;
            frac_full        = hue_fold - 9'(2 * SECTOR_DEG);
        end
        else if (hue_fold >= SECTOR_DEG)
        begin
            data_next.sector = SEC_YEL_GRN;
            frac_full        = hue_fold - SECTOR_DEG;
        end
        else
        begin
            data_next.sector = SEC_RED_YEL;
            frac_full        = hue_fold;
        end
        data_next.frac = frac_full[FRAC_W-1:0];
        data_next.sat  = pix_in.saturation;
        data_next.val  = pix_in.brightness;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pix_in.ready)
        begin
            valid_reg <= pix_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_in.valid && pix_in.ready)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;
endmodule

// File: design/hsv2rgb_scale_stage.sv
// Stage 2: form the saturation products and the p numerator.
// Depends on hsv2rgb_pkg.
module hsv2rgb_scale_stage (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     up_valid,
    output logic                     up_ready,
    input  hsv2rgb_pkg::sect_data_t  up_data,
    output logic                     dn_valid,
    input  logic                     dn_ready,
    output hsv2rgb_pkg::scale_data_t dn_data
);
    import hsv2rgb_pkg::*;

    logic              valid_reg;
    scale_data_t       data_reg;
    scale_data_t       data_next;
    logic [FRAC_W-1:0] frac_rest;
    logic [NUM_W-1:0]  s_frac;
    logic [NUM_W-1:0]  s_rest;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        frac_rest = FRAC_W'(SECTOR_DEG) - up_data.frac;
        s_frac    = NUM_W'(up_data.sat) * NUM_W'(up_data.frac);
        s_rest    = NUM_W'(up_data.sat) * NUM_W'(frac_rest);
        data_next.sector = up_data.sector;
        data_next.val    = up_data.val;
        data_next.q_num  = FRAC_SCALE - s_frac;
        data_next.t_num  = FRAC_SCALE - s_rest;
        data_next.p_prod = PP_W'(up_data.val) * PP_W'(CH_MAX - up_data.sat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;
endmodule

// File: design/hsv2rgb_mult_stage.sv
// Stage 3: scale the q and t numerators by value and divide p by 255.
// Depends on hsv2rgb_pkg.
module hsv2rgb_mult_stage (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     up_valid,
    output logic                     up_ready,
    input  hsv2rgb_pkg::scale_data_t up_data,
    output logic                     dn_valid,
    input  logic                     dn_ready,
    output hsv2rgb_pkg::mult_data_t  dn_data
);
    import hsv2rgb_pkg::*;

    logic               valid_reg;
    mult_data_t         data_reg;
    mult_data_t         data_next;
    logic [P_MUL_W-1:0] p_mul;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        p_mul = P_MUL_W'(up_data.p_prod) * P_MUL_W'(P_RECIP);
        data_next.sector = up_data.sector;
        data_next.val    = up_data.val;
        data_next.q_prod = QP_W'(up_data.val) * QP_W'(up_data.q_num);
        data_next.t_prod = QP_W'(up_data.val) * QP_W'(up_data.t_num);
        data_next.p      = p_mul[31:24];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;
endmodule

// File: design/hsv2rgb_select_stage.sv
// Stage 4: divide q and t by 15300 and route p, q, t, v to the channels.
// Depends on hsv2rgb_pkg and the channel interfaces.
module hsv2rgb_select_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    up_valid,
    output logic                    up_ready,
    input  hsv2rgb_pkg::mult_data_t up_data,
    hsv2rgb_rgb_if.source           pix_out
);
    import hsv2rgb_pkg::*;

    logic               valid_reg;
    logic [CH_W-1:0]    red_reg;
    logic [CH_W-1:0]    green_reg;
    logic [CH_W-1:0]    blue_reg;
    logic [CH_W-1:0]    red_next;
    logic [CH_W-1:0]    green_next;
    logic [CH_W-1:0]    blue_next;
    logic [Q_MUL_W-1:0] q_mul;
    logic [Q_MUL_W-1:0] t_mul;
    logic [CH_W-1:0]    q;
    logic [CH_W-1:0]    t;
    logic [CH_W-1:0]    p;
    logic [CH_W-1:0]    v;

    assign up_ready = !valid_reg || pix_out.ready;

    always_comb
    begin
        q_mul = Q_MUL_W'(up_data.q_prod) * Q_MUL_W'(Q_RECIP);
        t_mul = Q_MUL_W'(up_data.t_prod) * Q_MUL_W'(Q_RECIP);
        q     = q_mul[43:36];
        t     = t_mul[43:36];
        p     = up_data.p;
        v     = up_data.val;
        unique case (up_data.sector)
            SEC_RED_YEL: begin red_next = v; green_next = t; blue_next = p; end
            SEC_YEL_GRN: begin red_next = q; green_next = v; blue_next = p; end
            SEC_GRN_CYN: begin red_next = p; green_next = v; blue_next = t; end
            SEC_CYN_BLU: begin red_next = p; green_next = q; blue_next = v; end
            SEC_BLU_MAG: begin red_next = t; green_next = p; blue_next = v; end
            default:     begin red_next = v; green_next = p; blue_next = q; end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign pix_out.valid = valid_reg;
    assign pix_out.red   = red_reg;
    assign pix_out.green = green_reg;
    assign pix_out.blue  = blue_reg;
endmodule

// File: design/hsv_to_rgb_converter_unit.sv
// HSV to RGB converter, top level: four-stage pipeline.
// Depends on hsv2rgb_pkg, the channel interfaces and the four stage modules.
//
// Usage:
//   pix_in carries one pixel per transfer: hue in degrees (0..360, 360 is
//   taken as 0; larger codes have 360 taken off once), saturation and
//   brightness as n/255. pix_out returns red, green and blue, truncated.
//   Both channels transfer when valid and ready are high at a clock edge.
// Path: a pixel is registered by the sector, scale, mult and select stages.
// Throughput: one pixel per cycle while pix_out is taken; the multipliers
//   are split over stages 2 to 4 (saturation products, value products,
//   reciprocal divides).
// Stall: each stage holds its item while the next stage is full, so an
//   empty stage still takes a pixel; pix_in.ready drops only once all four
//   stages hold a pixel and pix_out is not taken.
// Reset: rst_n clears all stage valid bits at once; the pipeline is empty
//   and ready as soon as reset is released.
module hsv_to_rgb_converter_unit (
    input  logic          clk,
    input  logic          rst_n,
    hsv2rgb_hsv_if.sink   pix_in,
    hsv2rgb_rgb_if.source pix_out
);
    import hsv2rgb_pkg::*;

    logic        s1_valid;
    logic        s1_ready;
    sect_data_t  s1_data;
    logic        s2_valid;
    logic        s2_ready;
    scale_data_t s2_data;
    logic        s3_valid;
    logic        s3_ready;
    mult_data_t  s3_data;

    hsv2rgb_sector_stage u_sector (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix_in   (pix_in),
        .dn_valid (s1_valid),
        .dn_ready (s1_ready),
        .dn_data  (s1_data)
    );

    hsv2rgb_scale_stage u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_ready (s1_ready),
        .up_data  (s1_data),
        .dn_valid (s2_valid),
        .dn_ready (s2_ready),
        .dn_data  (s2_data)
    );

    hsv2rgb_mult_stage u_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s2_valid),
        .up_ready (s2_ready),
        .up_data  (s2_data),
        .dn_valid (s3_valid),
        .dn_ready (s3_ready),
        .dn_data  (s3_data)
    );

    hsv2rgb_select_stage u_select (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s3_valid),
        .up_ready (s3_ready),
        .up_data  (s3_data),
        .pix_out  (pix_out)
    );

`ifndef SYNTH
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid && !s1_ready) |=> (s1_valid && $stable(s1_data)))
        else $error("stage 1 item changed while stalled");

    a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid && !s3_ready) |=> (s3_valid && $stable(s3_data)))
        else $error("stage 3 item changed while stalled");

    a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid && s2_valid && s3_valid && pix_out.valid && !pix_out.ready)
        |-> !pix_in.ready)
        else $error("input taken with full, stalled pipeline");

    a_p_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid |-> (s3_data.p <= s3_data.val))
        else $error("p exceeds value");
`endif
endmodule
